### rtl/core/pd_pkg.sv
// ----------------------------------------------------------------------------
// Percent decoder package
// Shared types, character codes, phase codes and the hex digit helper.
// ----------------------------------------------------------------------------
package pd_pkg;

  localparam logic [7:0] PctChar   = 8'h25;
  localparam logic [7:0] SlashChar = 8'h2F;

  // Escape phase codes.
  localparam logic [1:0] PhIdle = 2'd0;
  localparam logic [1:0] PhPct  = 2'd1;
  localparam logic [1:0] PhHeld = 2'd2;

  // Result queue depth; two free entries are needed before an item is taken.
  localparam int unsigned QDepth = 4;

  typedef struct packed {
    logic       err;
    logic       last;
    logic [7:0] data;
  } res_item_t;

  typedef struct packed {
    logic [1:0] count;
    res_item_t  r0;
    res_item_t  r1;
  } dec_res_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_digit(input logic [7:0] b);
    hex_t h;
    h.valid = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h37);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h57);
    end else begin
      h.valid = 1'b0;
    end
    return h;
  endfunction

endpackage

### rtl/core/pd_decode.sv
// ----------------------------------------------------------------------------
// Percent decoder escape engine
// Holds the escape phase, the held byte and the drop flag, and turns each
// accepted byte into zero, one or two result items.
// ----------------------------------------------------------------------------
module pd_decode import pd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output dec_res_t   res_o
);

  logic [1:0] phase_q, phase_d;
  logic [7:0] held_q, held_d;
  logic       drop_q, drop_d;
  hex_t       h1, h2;
  logic [7:0] val;

  always_comb begin
    h1 = hex_digit(held_q);
    h2 = hex_digit(byte_i);
    if (!h1.valid) begin
      val = 8'd0;
    end else if (!h2.valid) begin
      val = {4'd0, h1.value};
    end else begin
      val = {h1.value, h2.value};
    end
  end

  always_comb begin
    phase_d = phase_q;
    held_d  = held_q;
    drop_d  = drop_q;
    res_o   = '0;
    if (drop_q) begin
      if (last_i) begin
        drop_d = 1'b0;
      end
    end else begin
      unique case (phase_q)
        PhPct: begin
          if (last_i) begin
            phase_d     = PhIdle;
            res_o.count = 2'd2;
            res_o.r0    = '{err: 1'b0, last: 1'b0, data: PctChar};
            res_o.r1    = '{err: 1'b0, last: 1'b1, data: byte_i};
          end else begin
            held_d  = byte_i;
            phase_d = PhHeld;
          end
        end
        PhHeld: begin
          phase_d     = PhIdle;
          res_o.count = 2'd1;
          if (val == 8'd0) begin
            drop_d   = !last_i;
            res_o.r0 = '{err: 1'b1, last: 1'b1, data: 8'd0};
          end else begin
            res_o.r0 = '{err: 1'b0, last: last_i,
                         data: (val == SlashChar) ? PctChar : val};
          end
        end
        default: begin
          // The unused fourth phase code behaves as idle.
          phase_d = PhIdle;
          if (byte_i == PctChar && !last_i) begin
            phase_d = PhPct;
          end else begin
            res_o.count = 2'd1;
            res_o.r0    = '{err: 1'b0, last: last_i, data: byte_i};
          end
        end
      endcase
    end
    if (!fire_i) begin
      phase_d     = phase_q;
      held_d      = held_q;
      drop_d      = drop_q;
      res_o.count = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      held_q  <= 8'd0;
      drop_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      held_q  <= held_d;
      drop_q  <= drop_d;
    end
  end

endmodule

### rtl/core/pd_outq.sv
// ----------------------------------------------------------------------------
// Percent decoder result queue
// Small register queue taking up to two result items per cycle and
// presenting one per cycle on the output stream while the consumer pops.
// ----------------------------------------------------------------------------
module pd_outq import pd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  dec_res_t  push_i,
  input  logic      pop_i,
  output logic      room_o,
  output logic      valid_o,
  output res_item_t head_o
);

  localparam int unsigned PtrW = $clog2(QDepth);
  localparam int unsigned CntW = $clog2(QDepth + 1);

  res_item_t       mem_q [QDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [PtrW-1:0] wr_ptr_nx;

  assign valid_o   = (cnt_q != '0);
  assign head_o    = mem_q[rd_ptr_q];
  assign room_o    = (cnt_q <= CntW'(QDepth - 2));
  assign wr_ptr_nx = wr_ptr_q + PtrW'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + PtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + PtrW'(pop_i);
    cnt_d    = cnt_q + CntW'(push_i.count) - CntW'(pop_i);
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_ptr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_ptr_nx] <= push_i.r1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

### rtl/core/percent_decoder.sv
// ----------------------------------------------------------------------------
// Percent decoder
// Streaming URL percent decoder, one encoded byte per transaction.
// ----------------------------------------------------------------------------
// A byte's results are registered in the result queue when the byte is
// accepted, and are offered on the master side from there.
// Throughput: one byte per cycle; the slave side stalls while the four-entry
// result queue holds more than two items, as after a two-result flush.
// Reset: asynchronous, active low; clears the escape phase, drop flag and
// queue, so both sides start empty.
module percent_decoder import pd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_axis_tvalid_i,
  output logic       s_axis_tready_o,
  input  logic [7:0] s_axis_tdata_i,  // [7:0] in_byte
  input  logic       s_axis_tlast_i,
  output logic       m_axis_tvalid_o,
  input  logic       m_axis_tready_i,
  output logic [7:0] m_axis_tdata_o,  // [7:0] out_byte
  output logic       m_axis_tlast_o,
  output logic       m_axis_tuser_o   // [0] out_error
);

  logic      in_fire, room;
  dec_res_t  dec_res;
  res_item_t head;

  assign s_axis_tready_o = room;
  assign in_fire         = s_axis_tvalid_i && room;

  pd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (in_fire),
    .byte_i (s_axis_tdata_i),
    .last_i (s_axis_tlast_i),
    .res_o  (dec_res)
  );

  pd_outq u_outq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (dec_res),
    .pop_i   (m_axis_tvalid_o && m_axis_tready_i),
    .room_o  (room),
    .valid_o (m_axis_tvalid_o),
    .head_o  (head)
  );

  assign m_axis_tdata_o = head.data;
  assign m_axis_tlast_o = head.last;
  assign m_axis_tuser_o = head.err;

endmodule

### rtl/core/pd_checker.sv
// ----------------------------------------------------------------------------
// Percent decoder checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module pd_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       m_axis_tvalid_o,
  input logic       m_axis_tready_i,
  input logic [7:0] m_axis_tdata_o,
  input logic       m_axis_tlast_o,
  input logic       m_axis_tuser_o
);

  // An error result always closes its string and carries a zero byte.
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tlast_o)
    else $error("error result without last");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o |-> m_axis_tdata_o == 8'd0)
    else $error("error result with non-zero byte");

  // Nothing is offered while reset is held.
  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |-> !m_axis_tvalid_o)
    else $error("result offered during reset");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("tvalid dropped while stalled");

  a_data_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      $stable(m_axis_tdata_o) && $stable(m_axis_tlast_o) && $stable(m_axis_tuser_o))
    else $error("payload changed while stalled");

endmodule

bind percent_decoder pd_checker u_pd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tlast_o  (m_axis_tlast_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);
